### hdl/reply_header_parser_assert.svh
// Assertion macros for the reply header parser.
`ifndef REPLY_HEADER_PARSER_ASSERT_SVH
`define REPLY_HEADER_PARSER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define RHP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define RHP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/rhp_pkg.sv
package rhp_pkg;

	localparam int MAX_LINE_DEF = 256;
	localparam int HOST_DIGITS = 8;
	localparam int DIGIT_CNT_W = 4;
	localparam int HOST_W = 32;
	localparam int OFFSET_W = 9;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LBR = 8'h5B;
	localparam logic [7:0] CH_RBR = 8'h5D;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_F = 8'h46;

	typedef enum logic [2:0] {
		ST_PENDING,
		ST_EOL,
		ST_PROMPT,
		ST_COMPLETE,
		ST_FAIL
	} status_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_PROMPT,
		MODE_HEADER
	} mode_t;

	typedef struct packed {
		logic is_eol;
		logic is_colon;
		logic is_lbr;
		logic is_rbr;
		logic is_gt;
		logic is_hex;
		logic [3:0] digit;
		logic last;
	} byte_class_t;

	function automatic byte_class_t classify(input logic [7:0] b, input logic last);
		byte_class_t c;
		logic upper_hex;
		logic dec_digit;
		upper_hex = (b >= CH_A) && (b <= CH_F);
		dec_digit = (b >= CH_0) && (b <= CH_9);
		c.is_eol = (b == CH_LF) || (b == CH_CR) || (b == CH_NUL);
		c.is_colon = (b == CH_COLON);
		c.is_lbr = (b == CH_LBR);
		c.is_rbr = (b == CH_RBR);
		c.is_gt = (b == CH_GT);
		c.is_hex = upper_hex || dec_digit;
		c.digit = upper_hex ? (b[3:0] + 4'd9) : b[3:0];
		c.last = last;
		return c;
	endfunction

endpackage

### hdl/rhp_front.sv
module rhp_front
	import rhp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        last_byte,
	output logic        cls_valid,
	input  logic        cls_pop,
	output byte_class_t cls
);

	byte_class_t slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;

	assign in_ready = (count_q != 2'd2);
	assign push = in_valid && in_ready;
	assign cls_valid = (count_q != 2'd0);
	assign pop = cls_pop && cls_valid;
	assign cls = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= classify(rx_byte, last_byte);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hdl/rhp_back.sv
module rhp_back
	import rhp_pkg::*;
#(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cls_valid,
	output logic                cls_pop,
	input  byte_class_t         cls,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic [HOST_W-1:0]   host_number,
	output logic [OFFSET_W-1:0] payload_offset
);

	localparam int POS_W = $clog2(MAX_LINE);
	localparam int OFF_W = (POS_W + 1 > OFFSET_W) ? POS_W + 1 : OFFSET_W;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LINE - 1);

	mode_t                  mode_q, mode_d;
	logic [POS_W-1:0]       brk_q, brk_d;
	logic                   colon_q, colon_d;
	logic [DIGIT_CNT_W-1:0] cnt_q, cnt_d;
	logic [HOST_W-1:0]      val_q, val_d;
	logic                   nonhex_q, nonhex_d;
	logic [POS_W-1:0]       pos_q, pos_d;
	logic                   prev_hex_q, prev_hex_d;
	logic [3:0]             prev_digit_q, prev_digit_d;

	logic                   out_valid_q;
	status_t                status_q;
	logic [HOST_W-1:0]      host_q;
	logic [OFFSET_W-1:0]    off_q;

	status_t                dec_status;
	logic [HOST_W-1:0]      dec_host;
	logic [OFFSET_W-1:0]    dec_off;
	logic                   dec_take;
	logic                   line_last;
	logic                   cnt_full;
	logic [OFF_W-1:0]       off_full;
	logic                   in_window;

	assign cls_pop = cls_valid && (!out_valid_q || out_ready);
	assign line_last = cls.last || (pos_q >= POS_LAST);
	assign cnt_full = (cnt_q >= DIGIT_CNT_W'(HOST_DIGITS));
	assign off_full = OFF_W'(pos_q) + OFF_W'(1);
	assign in_window = ({1'b0, pos_q} >= ({1'b0, brk_q} + (POS_W + 1)'(2)));

	always_comb begin
		dec_status = ST_PENDING;
		dec_host = '0;
		dec_off = '0;
		dec_take = 1'b0;
		case (mode_q)
			MODE_IDLE: begin
				if (cls.is_eol) begin
					dec_status = ST_EOL;
				end
			end
			MODE_PROMPT: begin
				if (cls.is_gt) begin
					dec_status = ST_PROMPT;
					dec_off = off_full[OFFSET_W-1:0];
				end
			end
			MODE_HEADER: begin
				if (colon_q && cls.is_rbr) begin
					if (cnt_full) begin
						dec_status = ST_COMPLETE;
						dec_host = val_q;
						dec_off = off_full[OFFSET_W-1:0];
					end else if (nonhex_q) begin
						dec_status = ST_FAIL;
					end
				end
				dec_take = (dec_status == ST_PENDING) && in_window;
			end
			default: begin
				dec_status = ST_PENDING;
			end
		endcase
		if (dec_status == ST_PENDING && line_last) begin
			dec_status = ST_FAIL;
		end
	end

	always_comb begin
		mode_d = mode_q;
		brk_d = brk_q;
		colon_d = colon_q;
		cnt_d = cnt_q;
		val_d = val_q;
		nonhex_d = nonhex_q;
		pos_d = pos_q + POS_W'(1);
		prev_hex_d = cls.is_hex;
		prev_digit_d = cls.digit;
		case (mode_q)
			MODE_IDLE: begin
				if (cls.is_colon) begin
					mode_d = MODE_PROMPT;
					brk_d = pos_q;
				end else if (cls.is_lbr) begin
					mode_d = MODE_HEADER;
					brk_d = pos_q;
				end
			end
			MODE_HEADER: begin
				if (!colon_q && cls.is_colon) begin
					colon_d = 1'b1;
				end
				if (dec_take && !cnt_full && !nonhex_q) begin
					if (prev_hex_q) begin
						val_d = {val_q[HOST_W-5:0], prev_digit_q};
						cnt_d = cnt_q + DIGIT_CNT_W'(1);
					end else begin
						nonhex_d = 1'b1;
					end
				end
			end
			default: begin
				mode_d = mode_q;
			end
		endcase
		if (dec_status != ST_PENDING) begin
			mode_d = MODE_IDLE;
			brk_d = '0;
			colon_d = 1'b0;
			cnt_d = '0;
			val_d = '0;
			nonhex_d = 1'b0;
			pos_d = '0;
			prev_hex_d = 1'b0;
			prev_digit_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			brk_q <= '0;
			colon_q <= 1'b0;
			cnt_q <= '0;
			val_q <= '0;
			nonhex_q <= 1'b0;
			pos_q <= '0;
			prev_hex_q <= 1'b0;
			prev_digit_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cls_pop) begin
				mode_q <= mode_d;
				brk_q <= brk_d;
				colon_q <= colon_d;
				cnt_q <= cnt_d;
				val_q <= val_d;
				nonhex_q <= nonhex_d;
				pos_q <= pos_d;
				prev_hex_q <= prev_hex_d;
				prev_digit_q <= prev_digit_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cls_pop) begin
			status_q <= dec_status;
			host_q <= dec_host;
			off_q <= dec_off;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign host_number = host_q;
	assign payload_offset = off_q;

endmodule

### hdl/reply_header_parser.sv
// An accepted byte passes through a queue slot and then the result register before its result is presented.
// Throughput: one byte per cycle while the output is not stalled, as the parse state updates on each byte taken.
// A two-entry byte queue lets input keep flowing while the output stalls, until both entries are full.
// Reset (arst_n low) clears the parse state, empties the queue and drops out_valid.
`include "reply_header_parser_assert.svh"

module reply_header_parser
	import rhp_pkg::*;
#(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	input  logic                last_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic [HOST_W-1:0]   host_number,
	output logic [OFFSET_W-1:0] payload_offset
);

	byte_class_t cls;
	logic        cls_valid;
	logic        cls_pop;
	logic        res_not_complete;
	logic        res_no_offset;

	rhp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.last_byte (last_byte),
		.cls_valid (cls_valid),
		.cls_pop   (cls_pop),
		.cls       (cls)
	);

	rhp_back #(
		.MAX_LINE (MAX_LINE)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cls_valid      (cls_valid),
		.cls_pop        (cls_pop),
		.cls            (cls),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.host_number    (host_number),
		.payload_offset (payload_offset)
	);

	assign res_not_complete = out_valid && (status != ST_COMPLETE);
	assign res_no_offset = out_valid
		&& (status == ST_PENDING || status == ST_EOL || status == ST_FAIL);

	`RHP_ASSERT_NOW(a_host_only_complete, res_not_complete, host_number == '0, "host without complete")
	`RHP_ASSERT_NOW(a_offset_only_decided, res_no_offset, payload_offset == '0, "offset without decision")
	`RHP_ASSERT_NOW(a_full_only_stalled, !in_ready, out_valid, "input stalled with no result waiting")
	`RHP_ASSERT_NEXT(a_result_follows, in_valid && in_ready, cls_valid, "accepted transaction not queued")

endmodule

### tb/sv/reply_header_parser_checker.sv
`timescale 1ns / 1ps

module reply_header_parser_checker
	import rhp_pkg::*;
#(
	parameter int LINE_MAX = MAX_LINE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [7:0]          rx_byte,
	input  logic                last_byte,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [2:0]          status,
	input  logic [HOST_W-1:0]   host_number,
	input  logic [OFFSET_W-1:0] payload_offset,
	output int unsigned         mismatches,
	output int unsigned         awaited
);

	typedef struct packed {
		status_t               st;
		logic [HOST_W-1:0]     host;
		logic [OFFSET_W-1:0]   offset;
	} reply_t;

	reply_t expected_replies[$];
	reply_t want;
	reply_t next_reply;
	int unsigned fails;

	mode_t                  mode_r;
	logic [OFFSET_W-1:0]    marker_pos;
	logic                   colon_r;
	logic [DIGIT_CNT_W-1:0] digit_cnt;
	logic [HOST_W-1:0]      digit_acc;
	logic                   bad_digit;
	logic [OFFSET_W-1:0]    next_pos;
	logic [7:0]             prior_byte;

	task automatic clear_parse();
		mode_r = MODE_IDLE;
		marker_pos = '0;
		colon_r = 1'b0;
		digit_cnt = '0;
		digit_acc = '0;
		bad_digit = 1'b0;
		next_pos = '0;
		prior_byte = '0;
	endtask

	// take the byte before the current one into the host number window
	task automatic take_digit(input logic [7:0] c);
		logic [7:0] dv;
		dv = '0;
		if (digit_cnt >= HOST_DIGITS || bad_digit)
			return;
		if (c >= CH_A && c <= CH_F) begin
			dv = c - CH_A + 8'd10;
		end else if (c >= CH_0 && c <= CH_9) begin
			dv = c - CH_0;
		end else begin
			bad_digit = 1'b1;
			return;
		end
		digit_acc = {digit_acc[HOST_W-5:0], dv[3:0]};
		digit_cnt = digit_cnt + 1'b1;
	endtask

	task automatic parse_reply_byte(input logic [7:0] b, input logic lst, output reply_t r);
		logic [OFFSET_W-1:0] pos;
		status_t st;
		logic l;
		pos = next_pos;
		st = ST_PENDING;
		l = lst;
		r.host = '0;
		r.offset = '0;
		if (int'(pos) >= LINE_MAX - 1)
			l = 1'b1;
		case (mode_r)
			MODE_IDLE: begin
				if (b == CH_LF || b == CH_CR || b == CH_NUL) begin
					st = ST_EOL;
				end else if (b == CH_COLON) begin
					mode_r = MODE_PROMPT;
					marker_pos = pos;
				end else if (b == CH_LBR) begin
					mode_r = MODE_HEADER;
					marker_pos = pos;
				end
			end
			MODE_PROMPT: begin
				if (b == CH_GT) begin
					st = ST_PROMPT;
					r.offset = pos + 1'b1;
				end
			end
			default: begin
				if (!colon_r) begin
					if (b == CH_COLON)
						colon_r = 1'b1;
				end else if (b == CH_RBR) begin
					if (digit_cnt >= HOST_DIGITS) begin
						st = ST_COMPLETE;
						r.host = digit_acc;
						r.offset = pos + 1'b1;
					end else if (bad_digit) begin
						st = ST_FAIL;
					end
				end
				if (st == ST_PENDING && {1'b0, pos} >= {1'b0, marker_pos} + 10'd2)
					take_digit(prior_byte);
			end
		endcase
		prior_byte = b;
		if (st == ST_PENDING && l)
			st = ST_FAIL;
		if (st != ST_PENDING)
			clear_parse();
		else
			next_pos = pos + 1'b1;
		r.st = st;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			expected_replies.delete();
			fails = 0;
			mismatches <= 0;
			awaited <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_replies.size() == 0) begin
					$error("unexpected transaction: status %0d host %0h offset %0d",
						status, host_number, payload_offset);
					fails++;
				end else begin
					want = expected_replies.pop_front();
					if (status !== want.st) begin
						$error("status expected %0d actual %0d", want.st, status);
						fails++;
					end
					if (host_number !== want.host) begin
						$error("host_number expected %0h actual %0h", want.host, host_number);
						fails++;
					end
					if (payload_offset !== want.offset) begin
						$error("payload_offset expected %0d actual %0d",
							want.offset, payload_offset);
						fails++;
					end
				end
			end
			if (in_valid && in_ready) begin
				parse_reply_byte(rx_byte, last_byte, next_reply);
				expected_replies.push_back(next_reply);
			end
			mismatches <= fails;
			awaited <= expected_replies.size();
		end
	end

endmodule

### tb/sv/reply_header_parser_tb.sv
`timescale 1ns / 1ps

module reply_header_parser_tb;
	import rhp_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          rx_byte = '0;
	logic                last_byte = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [2:0]          status;
	logic [HOST_W-1:0]   host_number;
	logic [OFFSET_W-1:0] payload_offset;
	int unsigned         mismatches;
	int unsigned         awaited;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned sent_bytes = 0;
	int unsigned send_pcts[4] = '{0, 81, 0, 32};
	int unsigned stall_pcts[4] = '{0, 0, 81, 32};
	logic [7:0]  line_bytes[$];

	reply_header_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.host_number   (host_number),
		.payload_offset(payload_offset)
	);

	reply_header_parser_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.host_number   (host_number),
		.payload_offset(payload_offset),
		.mismatches    (mismatches),
		.awaited       (awaited)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [7:0] hex_char();
		logic [3:0] d;
		d = 4'($urandom_range(15));
		return (d < 10) ? CH_0 + d : CH_A + d - 8'd10;
	endfunction

	function automatic logic [7:0] noise_char();
		logic [7:0] v;
		v = 8'($urandom_range(255));
		while (v == CH_LF || v == CH_CR || v == CH_NUL || v == CH_COLON || v == CH_LBR)
			v = 8'($urandom_range(255));
		return v;
	endfunction

	function automatic logic [7:0] any_but(input logic [7:0] x);
		logic [7:0] v;
		v = 8'($urandom_range(255));
		return (v == x) ? v ^ 8'h01 : v;
	endfunction

	function automatic logic [7:0] bad_digit_char();
		if ($urandom_range(1))
			return 8'h61 + 8'($urandom_range(5));
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] mixed_char();
		case ($urandom_range(7))
			0: return CH_COLON;
			1: return CH_LBR;
			2: return CH_RBR;
			3: return CH_GT;
			4: return hex_char();
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic lst);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		last_byte <= lst;
		do @(posedge clk); while (!in_ready);
		sent_bytes++;
	endtask

	task automatic push_text(input string s);
		foreach (s[i])
			line_bytes.push_back(s[i]);
	endtask

	task automatic send_line(input int unsigned how);
		int unsigned cut;
		cut = line_bytes.size() - 1;
		if (how >= 8)
			cut = $urandom_range(line_bytes.size() - 1);
		for (int unsigned i = 0; i <= cut; i++)
			send_byte(line_bytes[i], (i == cut) && (how >= 6));
		line_bytes.delete();
	endtask

	task automatic build_line();
		int unsigned kind;
		int unsigned n;
		int unsigned spoil;
		kind = $urandom_range(99);
		if (kind < 15) begin
			repeat ($urandom_range(4)) line_bytes.push_back(noise_char());
			case ($urandom_range(2))
				0: line_bytes.push_back(CH_LF);
				1: line_bytes.push_back(CH_CR);
				default: line_bytes.push_back(CH_NUL);
			endcase
		end else if (kind < 35) begin
			repeat ($urandom_range(3)) line_bytes.push_back(noise_char());
			line_bytes.push_back(CH_COLON);
			repeat ($urandom_range(6)) line_bytes.push_back(any_but(CH_GT));
			line_bytes.push_back(CH_GT);
		end else if (kind < 70) begin
			repeat ($urandom_range(2)) line_bytes.push_back(noise_char());
			line_bytes.push_back(CH_LBR);
			spoil = ($urandom_range(9) == 0) ? $urandom_range(7) : 8;
			for (int unsigned i = 0; i < 8; i++)
				line_bytes.push_back((i == spoil) ? bad_digit_char() : hex_char());
			if ($urandom_range(4) == 0)
				repeat ($urandom_range(1, 2)) line_bytes.push_back(any_but(CH_COLON));
			line_bytes.push_back(CH_COLON);
			repeat ($urandom_range(4)) line_bytes.push_back(any_but(CH_RBR));
			line_bytes.push_back(CH_RBR);
		end else if (kind < 80) begin
			line_bytes.push_back(CH_LBR);
			repeat ($urandom_range(7)) line_bytes.push_back(hex_char());
			line_bytes.push_back(CH_COLON);
			line_bytes.push_back(CH_RBR);
		end else if (kind < 99) begin
			n = $urandom_range(1, 12);
			repeat (n) line_bytes.push_back(mixed_char());
		end else if ($urandom_range(1)) begin
			repeat (256) line_bytes.push_back(noise_char());
		end else begin
			line_bytes.push_back(CH_COLON);
			repeat (254) line_bytes.push_back(any_but(CH_GT));
			line_bytes.push_back(CH_GT);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_byte(CH_LF, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_NUL, 1'b0);
		push_text(":>");
		send_line(0);
		push_text("[FEDCBA98:]");
		send_line(0);
		// lowercase hex counts as a bad digit
		push_text("[0a:]");
		send_line(0);
		line_bytes.push_back(8'hFF);
		send_line(6);
		drain();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_pcts[p];
			stall_pct = stall_pcts[p];
			sent_bytes = 0;
			while (sent_bytes < 410) begin
				build_line();
				send_line($urandom_range(9));
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### reply_header_parser.f
+incdir+hdl
hdl/rhp_pkg.sv
hdl/rhp_front.sv
hdl/rhp_back.sv
hdl/reply_header_parser.sv
tb/sv/reply_header_parser_checker.sv
tb/sv/reply_header_parser_tb.sv
